[rtl/core/qte_pkg.sv]
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants and the arctangent table of the quaternion to Euler core.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int WORK_FRAC = 28;   // fraction bits of the trig terms
  localparam int ANG_FRAC  = 20;   // fraction bits of the angle accumulator
  localparam int TABLE_LEN = 32;   // entries of the arctangent table

  localparam int QW  = 32;         // one aligned product, Q28
  localparam int TW  = 36;         // one trig term, Q28
  localparam int T2W = 30;         // clamped yaw term, Q28 in [-1, 1]
  localparam int RW  = 58;         // square root radicand and root work width
  localparam int SQ_STEPS = 29;    // root bits of a Q56 radicand
  localparam int CW  = 38;         // CORDIC vector coordinates
  localparam int ZW  = 31;         // CORDIC angle accumulator
  localparam int OW  = ZW - (ANG_FRAC - 7);  // angle in 1/128 degree

  localparam int PITCH_W = 16;
  localparam int YAW_W   = 15;
  localparam int ROLL_W  = 16;

  localparam logic signed [OW-1:0] LIMIT_180 = OW'(23040);
  localparam logic signed [OW-1:0] LIMIT_90  = OW'(11520);
  localparam logic signed [ZW-1:0] ANG_180   = ZW'(180) <<< ANG_FRAC;
  localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(1) <<< (ANG_FRAC - 8);

  // atan(2^-i) in units of 2^-20 degree, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_entry(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0: v = ZW'(47185920);
      1: v = ZW'(27855475);
      2: v = ZW'(14718068);
      3: v = ZW'(7471121);
      4: v = ZW'(3750058);
      5: v = ZW'(1876857);
      6: v = ZW'(938658);
      7: v = ZW'(469357);
      8: v = ZW'(234682);
      9: v = ZW'(117342);
      10: v = ZW'(58671);
      11: v = ZW'(29335);
      12: v = ZW'(14668);
      13: v = ZW'(7334);
      14: v = ZW'(3667);
      15: v = ZW'(1833);
      16: v = ZW'(917);
      17: v = ZW'(458);
      18: v = ZW'(229);
      19: v = ZW'(115);
      20: v = ZW'(57);
      21: v = ZW'(29);
      22: v = ZW'(14);
      23: v = ZW'(7);
      24: v = ZW'(4);
      25: v = ZW'(2);
      26: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/qte_if.sv]
// ----------------------------------------------------------------------------
// qte_if
// Valid/ready channels: quaternion items in, Euler angle items out.
// ----------------------------------------------------------------------------
interface qte_quat_if #(
  parameter int COMPONENT_BITS = 16
);
  logic                             valid;
  logic                             ready;
  logic signed [COMPONENT_BITS-1:0] quat_x;
  logic signed [COMPONENT_BITS-1:0] quat_y;
  logic signed [COMPONENT_BITS-1:0] quat_z;
  logic signed [COMPONENT_BITS-1:0] quat_w;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qte_euler_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qte_pkg::PITCH_W-1:0] pitch_deg;
  logic signed [qte_pkg::YAW_W-1:0]   yaw_deg;
  logic signed [qte_pkg::ROLL_W-1:0]  roll_deg;

  modport source (output valid, pitch_deg, yaw_deg, roll_deg, input ready);
  modport sink   (input valid, pitch_deg, yaw_deg, roll_deg, output ready);
endinterface

[rtl/core/quaternion_to_euler_angles_core.sv]
// Throughput: one quaternion per cycle; every stage holds when the output register stalls.
// The 29-stage square root of the yaw abscissa and the CORDIC stages set the latency.
// Reset (synchronous, active low) clears only the stage valid bits.
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core
// Converts a unit quaternion in signed fixed point to Tait-Bryan angles
// (pitch, yaw, roll) in 1/128 degree through a fully pipelined datapath.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_core #(
  parameter int COMPONENT_BITS = 16,
  parameter int CORDIC_STEPS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  qte_quat_if.sink    in_chan,
  qte_euler_if.source out_chan
);
  import qte_pkg::*;

  localparam int CB = COMPONENT_BITS;
  localparam int NS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  // Shift that brings a component product to the Q28 work format.
  localparam int D  = 2 * (CB - 2) - WORK_FRAC;
  localparam logic signed [TW-1:0] ONE_T = TW'(1) <<< WORK_FRAC;
  localparam logic [RW-1:0] ONE_SQ = RW'(1) << (2 * WORK_FRAC);

  // The whole pipeline advances together; the last stage is the output register.
  logic adv;
  logic out_valid_r;
  assign adv          = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;

  // --------------------------------------------------------------------------
  // Stage A: the nine component products.
  // Order: wx, yz, xx, yy, wy, zx, wz, xy, zz.
  // --------------------------------------------------------------------------
  logic signed [2*CB-1:0] prod_r [0:8];
  logic                   va_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r[0] <= in_chan.quat_w * in_chan.quat_x;
      prod_r[1] <= in_chan.quat_y * in_chan.quat_z;
      prod_r[2] <= in_chan.quat_x * in_chan.quat_x;
      prod_r[3] <= in_chan.quat_y * in_chan.quat_y;
      prod_r[4] <= in_chan.quat_w * in_chan.quat_y;
      prod_r[5] <= in_chan.quat_z * in_chan.quat_x;
      prod_r[6] <= in_chan.quat_w * in_chan.quat_z;
      prod_r[7] <= in_chan.quat_x * in_chan.quat_y;
      prod_r[8] <= in_chan.quat_z * in_chan.quat_z;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: align each product to Q28 (floor shift) and form the five terms.
  // --------------------------------------------------------------------------
  logic signed [QW-1:0] q [0:8];

  for (genvar k = 0; k < 9; k++) begin : g_align
    if (D >= 0) begin : g_down
      assign q[k] = QW'(64'(prod_r[k]) >>> D);
    end else begin : g_up
      assign q[k] = QW'(64'(prod_r[k]) <<< (-D));
    end
  end

  logic signed [TW-1:0] tb0_r, tb1_r, tb2_r, tb3_r, tb4_r;
  logic                 vb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tb0_r <= (TW'(q[0]) + TW'(q[1])) <<< 1;
      tb1_r <= ONE_T - ((TW'(q[2]) + TW'(q[3])) <<< 1);
      tb2_r <= (TW'(q[4]) - TW'(q[5])) <<< 1;
      tb3_r <= (TW'(q[6]) + TW'(q[7])) <<< 1;
      tb4_r <= ONE_T - ((TW'(q[3]) + TW'(q[8])) <<< 1);
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: clamp the yaw term to [-1, 1] and square it.
  // --------------------------------------------------------------------------
  logic signed [T2W-1:0] t2c;
  always_comb begin
    if (tb2_r > ONE_T) begin
      t2c = T2W'(ONE_T);
    end else if (tb2_r < -ONE_T) begin
      t2c = T2W'(-ONE_T);
    end else begin
      t2c = T2W'(tb2_r);
    end
  end

  // The square is formed at full product width; it never exceeds 2^56.
  logic signed [2*T2W-1:0] t2sq;
  assign t2sq = t2c * t2c;

  logic signed [TW-1:0]  tc0_r, tc1_r, tc3_r, tc4_r;
  logic signed [T2W-1:0] tc2_r;
  logic [RW-1:0]         sqc_r;
  logic                  vc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (adv) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tc0_r <= tb0_r;
      tc1_r <= tb1_r;
      tc3_r <= tb3_r;
      tc4_r <= tb4_r;
      tc2_r <= t2c;
      sqc_r <= RW'(t2sq);
    end
  end

  // --------------------------------------------------------------------------
  // Square root of 1 - t^2 (Q56 to Q28), one root bit per stage.
  // Index 0 holds the radicand; index j + 1 is the result of step j.
  // --------------------------------------------------------------------------
  logic [RW-1:0]         srem_r [0:SQ_STEPS];
  logic [RW-1:0]         sres_r [0:SQ_STEPS];
  logic signed [TW-1:0]  st0_r  [0:SQ_STEPS];
  logic signed [TW-1:0]  st1_r  [0:SQ_STEPS];
  logic signed [TW-1:0]  st3_r  [0:SQ_STEPS];
  logic signed [TW-1:0]  st4_r  [0:SQ_STEPS];
  logic signed [T2W-1:0] st2_r  [0:SQ_STEPS];
  logic                  vs_r   [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r[0] <= 1'b0;
    end else if (adv) begin
      vs_r[0] <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      srem_r[0] <= ONE_SQ - sqc_r;
      sres_r[0] <= '0;
      st0_r[0]  <= tc0_r;
      st1_r[0]  <= tc1_r;
      st2_r[0]  <= tc2_r;
      st3_r[0]  <= tc3_r;
      st4_r[0]  <= tc4_r;
    end
  end

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQ_STEPS - 1 - j));
    logic [RW-1:0] trial;
    logic          take;
    assign trial = sres_r[j] + BIT;
    assign take  = srem_r[j] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[j+1] <= 1'b0;
      end else if (adv) begin
        vs_r[j+1] <= vs_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        srem_r[j+1] <= take ? (srem_r[j] - trial) : srem_r[j];
        sres_r[j+1] <= take ? ((sres_r[j] >> 1) + BIT) : (sres_r[j] >> 1);
        st0_r[j+1]  <= st0_r[j];
        st1_r[j+1]  <= st1_r[j];
        st2_r[j+1]  <= st2_r[j];
        st3_r[j+1]  <= st3_r[j];
        st4_r[j+1]  <= st4_r[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC vectoring, three lanes: 0 pitch, 1 yaw, 2 roll.
  // Index 0 is the prerotation stage; index i + 1 is the result of step i.
  // A zero vector is flagged and gives angle zero at the output.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] lane_y [0:2];
  logic signed [CW-1:0] lane_x [0:2];
  assign lane_y[0] = CW'(st0_r[SQ_STEPS]);
  assign lane_x[0] = CW'(st1_r[SQ_STEPS]);
  assign lane_y[1] = CW'(st2_r[SQ_STEPS]);
  assign lane_x[1] = CW'(sres_r[SQ_STEPS][SQ_STEPS-1:0]);
  assign lane_y[2] = CW'(st3_r[SQ_STEPS]);
  assign lane_x[2] = CW'(st4_r[SQ_STEPS]);

  logic signed [CW-1:0] cx_r [0:NS][0:2];
  logic signed [CW-1:0] cy_r [0:NS][0:2];
  logic signed [ZW-1:0] cz_r [0:NS][0:2];
  logic                 cnil_r [0:NS][0:2];
  logic                 vk_r [0:NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vk_r[0] <= 1'b0;
    end else if (adv) begin
      vk_r[0] <= vs_r[SQ_STEPS];
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_pre
    always_ff @(posedge clk) begin
      if (adv) begin
        cnil_r[0][c] <= (lane_x[c] == '0) && (lane_y[c] == '0);
        if (lane_x[c] < 0) begin
          // Left half plane: turn by 180 degrees before refining.
          cx_r[0][c] <= -lane_x[c];
          cy_r[0][c] <= -lane_y[c];
          cz_r[0][c] <= (lane_y[c] >= 0) ? ANG_180 : -ANG_180;
        end else begin
          cx_r[0][c] <= lane_x[c];
          cy_r[0][c] <= lane_y[c];
          cz_r[0][c] <= '0;
        end
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] ATAN_I = atan_entry(i);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vk_r[i+1] <= 1'b0;
      end else if (adv) begin
        vk_r[i+1] <= vk_r[i];
      end
    end

    for (genvar c = 0; c < 3; c++) begin : g_lane
      logic signed [CW-1:0] xs, ys;
      assign xs = cx_r[i][c] >>> i;
      assign ys = cy_r[i][c] >>> i;

      always_ff @(posedge clk) begin
        if (adv) begin
          cnil_r[i+1][c] <= cnil_r[i][c];
          if (cy_r[i][c] >= 0) begin
            cx_r[i+1][c] <= cx_r[i][c] + ys;
            cy_r[i+1][c] <= cy_r[i][c] - xs;
            cz_r[i+1][c] <= cz_r[i][c] + ATAN_I;
          end else begin
            cx_r[i+1][c] <= cx_r[i][c] - ys;
            cy_r[i+1][c] <= cy_r[i][c] + xs;
            cz_r[i+1][c] <= cz_r[i][c] - ATAN_I;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: round half up to 1/128 degree and saturate.
  // --------------------------------------------------------------------------
  logic signed [OW-1:0] ang [0:2];
  logic signed [OW-1:0] sat [0:2];

  for (genvar c = 0; c < 3; c++) begin : g_round
    localparam logic signed [OW-1:0] LIM = (c == 1) ? LIMIT_90 : LIMIT_180;
    logic signed [ZW-1:0] zr;
    assign zr     = cz_r[NS][c] + ROUND_HALF;
    assign ang[c] = cnil_r[NS][c] ? '0 : OW'(zr >>> (ANG_FRAC - 7));
    assign sat[c] = (ang[c] > LIM) ? LIM : ((ang[c] < -LIM) ? -LIM : ang[c]);
  end

  logic signed [PITCH_W-1:0] pitch_r;
  logic signed [YAW_W-1:0]   yaw_r;
  logic signed [ROLL_W-1:0]  roll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vk_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pitch_r <= sat[0][PITCH_W-1:0];
      yaw_r   <= sat[1][YAW_W-1:0];
      roll_r  <= sat[2][ROLL_W-1:0];
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.pitch_deg = pitch_r;
  assign out_chan.yaw_deg   = yaw_r;
  assign out_chan.roll_deg  = roll_r;

endmodule

[bench/qte_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_tb_pkg
// Angle predictor and result scoreboard for the quaternion to Euler core.
// ----------------------------------------------------------------------------
package qte_tb_pkg;

  localparam int CBITS = 16;
  localparam int STEPS = 16;
  localparam longint ANGLE_180 = longint'(180) <<< 20;

  typedef struct packed {
    logic signed [15:0] pitch;
    logic signed [14:0] yaw;
    logic signed [15:0] roll;
  } euler_t;

  function automatic longint atan_step(int i);
    longint tab[27] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
                        938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334,
                        3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
    return (i < 27) ? tab[i] : 64'sd0;
  endfunction

  // Component product aligned to 28 fraction bits (exact at 16-bit components).
  function automatic longint prod_q28(longint a, longint b);
    longint p;
    int d;
    p = a * b;
    d = 2 * (CBITS - 2) - 28;
    if (d >= 0) return p >>> d;
    return p <<< (-d);
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // Vectoring CORDIC, angle in 2^-20 degree.
  function automatic longint vector_angle(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? ANGLE_180 : -ANGLE_180;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += atan_step(i);
      end else begin
        x = x - ys; y = y + xs; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint to_128th(longint z, longint lim);
    longint r;
    r = (z + (longint'(1) <<< 12)) >>> 13;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic euler_t quat_to_euler(logic signed [15:0] qx, logic signed [15:0] qy,
                                           logic signed [15:0] qz, logic signed [15:0] qw);
    longint x, y, z, w, one, t0, t1, t2, t3, t4, root;
    euler_t e;
    x = qx; y = qy; z = qz; w = qw;
    one = longint'(1) <<< 28;
    t0 = 2 * (prod_q28(w, x) + prod_q28(y, z));
    t1 = one - 2 * (prod_q28(x, x) + prod_q28(y, y));
    t2 = 2 * (prod_q28(w, y) - prod_q28(z, x));
    t3 = 2 * (prod_q28(w, z) + prod_q28(x, y));
    t4 = one - 2 * (prod_q28(y, y) + prod_q28(z, z));
    if (t2 > one) t2 = one;
    if (t2 < -one) t2 = -one;
    root = floor_sqrt(longint'(64'd1 << 56) - t2 * t2);
    e.pitch = 16'(to_128th(vector_angle(t0, t1), 23040));
    e.yaw   = 15'(to_128th(vector_angle(t2, root), 11520));
    e.roll  = 16'(to_128th(vector_angle(t3, t4), 23040));
    return e;
  endfunction

  class angle_scoreboard;
    euler_t pending[$];
    int errors;

    function void note_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                            logic signed [15:0] qz, logic signed [15:0] qw);
      pending.push_back(quat_to_euler(qx, qy, qz, qw));
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_angles(euler_t got);
      euler_t exp_e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %0d %0d %0d", got.pitch, got.yaw, got.roll));
        return;
      end
      exp_e = pending.pop_front();
      if (got.pitch !== exp_e.pitch)
        report($sformatf("pitch got %0d want %0d", got.pitch, exp_e.pitch));
      if (got.yaw !== exp_e.yaw)
        report($sformatf("yaw got %0d want %0d", got.yaw, exp_e.yaw));
      if (got.roll !== exp_e.roll)
        report($sformatf("roll got %0d want %0d", got.roll, exp_e.roll));
    endtask
  endclass

endpackage

[bench/tb_quaternion_to_euler_angles_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles_core
// Drives quaternions into the core with random gaps and output stalls, and
// checks every pitch, yaw and roll against a bit-exact angle predictor.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_angles_core;
  import qte_tb_pkg::*;

  localparam int RANDOM_ITEMS = 950;
  // Cycles without any transfer before the run is abandoned. The pipeline
  // latency plus the longest stall is well below this.
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 120;

  logic clk;
  logic rst_n;
  int   idle_cycles = 0;

  qte_quat_if  #(.COMPONENT_BITS(16)) in_chan ();
  qte_euler_if                        out_chan ();

  quaternion_to_euler_angles_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan.sink),
    .out_chan(out_chan.source)
  );

  angle_scoreboard angles_sb;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sends one quaternion after a random gap; inputs move on the falling edge.
  task automatic send_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                           logic signed [15:0] qz, logic signed [15:0] qw);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
    repeat (gap) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.quat_x <= qx;
    in_chan.quat_y <= qy;
    in_chan.quat_z <= qz;
    in_chan.quat_w <= qw;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // A random unit quaternion: four random components in [-1, 1], then
  // normalized in real arithmetic and scaled to Q2.14.
  task automatic send_unit_quat();
    real c[4];
    real n;
    for (int i = 0; i < 4; i++)
      c[i] = (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0;
    n = $sqrt(c[0]*c[0] + c[1]*c[1] + c[2]*c[2] + c[3]*c[3]);
    if (n < 1e-3) begin
      c[3] = 1.0; n = 1.0;
    end
    send_quat(16'($rtoi(c[0] / n * 16384.0)), 16'($rtoi(c[1] / n * 16384.0)),
              16'($rtoi(c[2] / n * 16384.0)), 16'($rtoi(c[3] / n * 16384.0)));
  endtask

  // Input transfers are noted and output transfers checked at the rising edge they happen on.
  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready)
      angles_sb.note_quat(in_chan.quat_x, in_chan.quat_y, in_chan.quat_z, in_chan.quat_w);
    if (rst_n && out_chan.valid && out_chan.ready)
      angles_sb.check_angles('{out_chan.pitch_deg, out_chan.yaw_deg, out_chan.roll_deg});
  end

  // Result side back-pressure: a random run of stalls, then a ready window.
  initial begin
    int hold;
    out_chan.ready = 1'b0;
    @(negedge clk);
    forever begin
      hold = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
      if (hold > 0) begin
        out_chan.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      @(negedge clk);
    end
  end

  // Watchdog: counts cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic signed [15:0] qmax, qmin;
    qmax = 16'sh7fff;
    qmin = 16'sh8000;
    angles_sb = new();
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.quat_x = '0;
    in_chan.quat_y = '0;
    in_chan.quat_z = '0;
    in_chan.quat_w = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: identity, axis turns, the all-zero quaternion,
    // negative abscissas, yaw term past +-1 and saturating extremes.
    send_quat(0, 0, 0, 16384);
    send_quat(16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 0);
    send_quat(11585, 0, 0, 11585);
    send_quat(0, 11585, 0, 11585);
    send_quat(0, 11585, 0, -11585);
    send_quat(0, 0, 11585, 11585);
    send_quat(16000, 0, 0, -3000);
    send_quat(-16000, 0, 0, -3000);
    send_quat(0, 0, 16000, -3000);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(-8192, 8192, -8192, 8192);
    send_quat(0, 16384, 0, 16384);
    send_quat(0, -16384, 0, 16384);
    send_quat(qmax, qmax, qmax, qmax);
    send_quat(qmin, qmin, qmin, qmin);
    send_quat(qmax, qmin, qmax, qmin);
    send_quat(qmin, qmax, qmin, qmax);
    send_quat(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
    send_quat(-1, -1, -1, -1);
    send_quat(1, 0, 0, 0);

    // Mostly unit quaternions, some raw 16-bit noise, in back-to-back bursts
    // as well as with gaps.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 4) == 0)
        send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else
        send_unit_quat();
    end
    in_chan.valid <= 1'b0;

    while (angles_sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (angles_sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
